[design/tuat_pkg.sv]
// ----------------------------------------------------------------------------
// tuat_pkg: shared types and constants for the tag UID action table
// Operation and status codes, the stored entry layout, controller states and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package tuat_pkg;

	// Longest UID in bytes; longer key lengths clamp to this
	localparam int UidBytes = 10;

	typedef logic [1:0] op_code_t;
	localparam op_code_t OpLookup = 2'd0;
	localparam op_code_t OpUpsert = 2'd1;
	localparam op_code_t OpRemove = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t StOk      = 2'd0;
	localparam status_t StMissing = 2'd1;
	localparam status_t StFull    = 2'd2;

	// One stored entry: normalized key plus action and parameter bytes
	typedef struct packed {
		logic [3:0]  len;
		logic [15:0] key_hi;
		logic [63:0] key_lo;
		logic [7:0]  param;
		logic [7:0]  action;
	} entry_t;

	// Result word as it leaves the block
	typedef struct packed {
		status_t     status;
		logic [7:0]  found_action;
		logic [7:0]  found_param;
		logic [4:0]  entry_count;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_MOVE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic exec;
		logic move;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic move_needed;
		logic out_free;
	} stat_t;

endpackage

[design/tuat_if.sv]
// ----------------------------------------------------------------------------
// tuat_if: request and response channels of the tag UID action table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tuat_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  key_length;
	logic [63:0] key_low;
	logic [15:0] key_high;
	logic [7:0]  tag_action;
	logic [7:0]  action_param;

	modport source (
		output valid, op, key_length, key_low, key_high, tag_action, action_param,
		input  ready
	);
	modport sink (
		input  valid, op, key_length, key_low, key_high, tag_action, action_param,
		output ready
	);
endinterface

interface tuat_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  found_action;
	logic [7:0]  found_param;
	logic [4:0]  entry_count;

	modport source (
		output valid, status, found_action, found_param, entry_count,
		input  ready
	);
	modport sink (
		input  valid, status, found_action, found_param, entry_count,
		output ready
	);
endinterface

[design/tuat_ctrl.sv]
// ----------------------------------------------------------------------------
// tuat_ctrl: sequencing controller of the tag UID action table
// Steps each word through scan, execute, optional move and response load.
// ----------------------------------------------------------------------------
module tuat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tuat_pkg::stat_t stat,
	output tuat_pkg::cmd_t  cmd
);

	tuat_pkg::state_t state_q;
	tuat_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tuat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tuat_pkg::S_IDLE: begin
				if (req_valid) state_d = tuat_pkg::S_SCAN;
			end
			tuat_pkg::S_SCAN: begin
				if (stat.scan_done) state_d = tuat_pkg::S_EXEC;
			end
			tuat_pkg::S_EXEC: begin
				state_d = stat.move_needed ? tuat_pkg::S_MOVE : tuat_pkg::S_RESP;
			end
			tuat_pkg::S_MOVE: begin
				state_d = tuat_pkg::S_RESP;
			end
			tuat_pkg::S_RESP: begin
				if (stat.out_free) state_d = tuat_pkg::S_IDLE;
			end
			default: begin
				state_d = tuat_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			tuat_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
			end
			tuat_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
			end
			tuat_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			tuat_pkg::S_MOVE: begin
				cmd.move = 1'b1;
			end
			tuat_pkg::S_RESP: begin
				cmd.load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[design/tuat_dp.sv]
// ----------------------------------------------------------------------------
// tuat_dp: datapath of the tag UID action table
// Key capture and normalization, entry memory, sequential search, update
// and the output register.
// ----------------------------------------------------------------------------
module tuat_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tuat_pkg::cmd_t  cmd,
	output tuat_pkg::stat_t stat,
	input  logic [1:0]      op,
	input  logic [3:0]      key_length,
	input  logic [63:0]     key_low,
	input  logic [15:0]     key_high,
	input  logic [7:0]      tag_action,
	input  logic [7:0]      action_param,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [1:0]      status,
	output logic [7:0]      found_action,
	output logic [7:0]      found_param,
	output logic [4:0]      entry_count
);

	localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FillW = $clog2(TABLE_DEPTH + 1);
	localparam logic [FillW-1:0] FillMax = FillW'(TABLE_DEPTH);

	// captured, normalized request
	tuat_pkg::op_code_t op_q;
	logic [3:0]         len_q;
	logic [63:0]        lo_q;
	logic [15:0]        hi_q;
	logic [7:0]         act_q;
	logic [7:0]         par_q;

	logic [3:0]         len_c;
	logic [63:0]        lo_n;
	logic [15:0]        hi_n;

	// search state
	logic [FillW-1:0]   fill_q;
	logic [FillW-1:0]   fill_m1;
	logic [FillW-1:0]   fill_next;
	logic [FillW+4:0]   cnt_ext;
	logic [FillW-1:0]   scan_idx_q;
	logic               issue_s1;
	logic [IdxW-1:0]    idx_s1;
	logic               found_q;
	logic [IdxW-1:0]    match_idx_q;
	logic [7:0]         match_act_q;
	logic [7:0]         match_par_q;
	logic               issue;
	logic               hit;
	logic               full;
	logic               is_upsert;
	logic               is_remove;

	// entry memory
	tuat_pkg::entry_t   mem_q [TABLE_DEPTH];
	tuat_pkg::entry_t   rd_data_q;
	tuat_pkg::entry_t   wr_data;
	logic               rd_en;
	logic [IdxW-1:0]    rd_addr;
	logic               wr_en;
	logic [IdxW-1:0]    wr_addr;

	tuat_pkg::result_t  res_d;
	tuat_pkg::result_t  res_q;
	tuat_pkg::result_t  out_q;
	logic               out_valid_q;

	// clamp the length and clear bytes beyond it
	always_comb begin
		len_c = (key_length > 4'(tuat_pkg::UidBytes)) ? 4'(tuat_pkg::UidBytes) : key_length;
		for (int b = 0; b < 8; b++) begin
			lo_n[8*b +: 8] = (4'(b) < len_c) ? key_low[8*b +: 8] : 8'h00;
		end
		for (int b = 0; b < 2; b++) begin
			hi_n[8*b +: 8] = (4'(8 + b) < len_c) ? key_high[8*b +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op;
			len_q <= len_c;
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			act_q <= tag_action;
			par_q <= action_param;
		end
	end

	assign is_upsert = (op_q == tuat_pkg::OpUpsert);
	assign is_remove = (op_q == tuat_pkg::OpRemove);
	assign full      = (fill_q == FillMax);
	assign fill_m1   = fill_q - 1'b1;

	assign hit = cmd.scan && issue_s1 && (rd_data_q.len == len_q) &&
		(rd_data_q.key_lo == lo_q) && (rd_data_q.key_hi == hi_q);
	// stop issuing reads once a match is seen; first match wins
	assign issue = cmd.scan && !found_q && !hit && (scan_idx_q != fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1   <= 1'b0;
			found_q    <= 1'b0;
			scan_idx_q <= '0;
		end else if (cmd.start) begin
			issue_s1   <= 1'b0;
			found_q    <= 1'b0;
			scan_idx_q <= '0;
		end else if (cmd.scan) begin
			issue_s1 <= issue;
			if (issue) scan_idx_q <= scan_idx_q + 1'b1;
			if (hit) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= scan_idx_q[IdxW-1:0];
		if (hit) begin
			match_idx_q <= idx_s1;
			match_act_q <= rd_data_q.action;
			match_par_q <= rd_data_q.param;
		end
	end

	// memory ports: reads for the scan and for the last entry on remove
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_idx_q[IdxW-1:0];
		if (issue) begin
			rd_en = 1'b1;
		end else if (cmd.exec && is_remove && found_q) begin
			rd_en   = 1'b1;
			rd_addr = fill_m1[IdxW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = match_idx_q;
		wr_data = rd_data_q;
		if (cmd.exec && is_upsert && (found_q || !full)) begin
			wr_en   = 1'b1;
			wr_addr = found_q ? match_idx_q : fill_q[IdxW-1:0];
			wr_data = '{len: len_q, key_hi: hi_q, key_lo: lo_q, param: par_q, action: act_q};
		end else if (cmd.move) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	// result of the operation and new fill count
	always_comb begin
		fill_next          = fill_q;
		res_d              = '0;
		res_d.status       = tuat_pkg::StOk;
		case (op_q)
			tuat_pkg::OpUpsert: begin
				if (!found_q) begin
					if (full) res_d.status = tuat_pkg::StFull;
					else fill_next = fill_q + 1'b1;
				end
			end
			tuat_pkg::OpRemove: begin
				if (found_q) fill_next = fill_m1;
				else res_d.status = tuat_pkg::StMissing;
			end
			default: begin
				if (found_q) begin
					res_d.found_action = match_act_q;
					res_d.found_param  = match_par_q;
				end else begin
					res_d.status = tuat_pkg::StMissing;
				end
			end
		endcase
		cnt_ext           = {5'b0, fill_next};
		res_d.entry_count = cnt_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.exec) begin
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) res_q <= res_d;
		if (cmd.load) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.scan_done   = !issue_s1 && (found_q || (scan_idx_q == fill_q));
	assign stat.move_needed = is_remove && found_q;
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign found_action = out_q.found_action;
	assign found_param  = out_q.found_param;
	assign entry_count  = out_q.entry_count;

endmodule

[design/tag_uid_action_table.sv]
// ----------------------------------------------------------------------------
// tag_uid_action_table: small content-addressed tag UID to action table
// Lookup, upsert and remove of UID keys with an action and parameter byte.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation word: op, key_length, key_low, key_high,
//   tag_action and action_param. rsp returns one word per request: status,
//   found_action, found_param and entry_count.
//   Keys are clamped to the UID length and bytes past key_length are ignored.
//   A request is taken only while the table is idle. It then scans the entry
//   memory from entry 0, one read per cycle on its single read port, and
//   stops at the first match. After the scan, lookup and upsert execute and
//   load the response; a remove that hits also passes through a move step,
//   which moves the last entry into the freed slot.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next request is still accepted and searched, and only that
//   request's response waits for the register to empty.
//   Reset empties the table (fill count to zero) and drops any pending word;
//   entry contents need no clearing, since only entries below the fill count
//   are ever read.
// ----------------------------------------------------------------------------
module tag_uid_action_table #(
	parameter int TABLE_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	tuat_req_if.sink   req,
	tuat_rsp_if.source rsp
);

	tuat_pkg::cmd_t  cmd;
	tuat_pkg::stat_t stat;

	// sequence each word: scan, execute, move, load result
	tuat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// hold keys, memory, fill count and the output register
	tuat_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (req.op),
		.key_length   (req.key_length),
		.key_low      (req.key_low),
		.key_high     (req.key_high),
		.tag_action   (req.tag_action),
		.action_param (req.action_param),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.status       (rsp.status),
		.found_action (rsp.found_action),
		.found_param  (rsp.found_param),
		.entry_count  (rsp.entry_count)
	);

	// an accepted word starts a search, so no second word is taken next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a search is running");

	// the controller issues at most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.scan, cmd.exec, cmd.move, cmd.load}))
		else $error("overlapping controller commands");

	// only known status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == tuat_pkg::StOk) ||
			(rsp.status == tuat_pkg::StMissing) || (rsp.status == tuat_pkg::StFull))
		else $error("unknown status code");

	// data bytes stay zero on any failure
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != tuat_pkg::StOk) |->
			(rsp.found_action == 8'h00) && (rsp.found_param == 8'h00))
		else $error("action data on a failed operation");

endmodule

[tb/tb_tag_uid_action_table.sv]
// ----------------------------------------------------------------------------
// tb_tag_uid_action_table: self-checking bench for the tag UID action table
// Sends lookup, upsert and remove words on the request channel and keeps a
// shadow copy of the table that predicts every response word. Each response
// is checked field by field against the oldest prediction. The sender works
// in bursts and the receiver stalls on patterns of its own, including one
// long hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_tag_uid_action_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TableDepth  = 16;
	localparam int PoolSize    = 24;
	localparam int RandomWords = 1700;
	localparam int PhaseWords  = 60;
	// No handshake on either side for this many cycles ends the run
	localparam int IdleLimit   = 2000;
	// Quiet stretch after the last response of each test
	localparam int DrainCycles = 60;
	localparam int HoldOff     = 400;

	// Op code 3 has no name in the package; the block treats it as a lookup
	localparam tuat_pkg::op_code_t OpSpare = 2'd3;

	typedef enum {TrGrow, TrChurn, TrShrink} traffic_t;
	typedef enum {RxOpen, RxRandom, RxPattern, RxSparse} rx_mode_t;

	typedef struct {
		tuat_pkg::op_code_t op;
		logic [3:0]         len;
		logic [63:0]        lo;
		logic [15:0]        hi;
		logic [7:0]         act;
		logic [7:0]         par;
	} req_word_t;

	logic clk = 1'b0;
	logic arst_n;

	tuat_req_if req();
	tuat_rsp_if rsp();

	tag_uid_action_table #(
		.TABLE_DEPTH(TableDepth)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow table: normalized keys, action and parameter bytes, fill count
	logic [63:0] ent_lo  [TableDepth];
	logic [15:0] ent_hi  [TableDepth];
	logic [3:0]  ent_len [TableDepth];
	logic [7:0]  ent_act [TableDepth];
	logic [7:0]  ent_par [TableDepth];
	int          ent_fill;

	// Response words predicted but not yet seen, oldest first
	tuat_pkg::result_t rsp_backlog[$];

	// Key pool for random traffic, stored normalized with lengths up to UidBytes
	logic [63:0] pool_lo  [PoolSize];
	logic [15:0] pool_hi  [PoolSize];
	logic [3:0]  pool_len [PoolSize];

	int fail_count   = 0;
	int idle_cycles  = 0;
	int hold_off_req = 0;
	int burst_left   = 0;
	bit steady_send  = 1'b1;

	// ------------------------------------------------------------------------
	// Key masks: keep the first len bytes, clear the rest
	// ------------------------------------------------------------------------
	function automatic logic [63:0] lo_mask(input logic [3:0] len);
		if (len >= 8)
			return '1;
		return (64'd1 << (8 * len)) - 64'd1;
	endfunction

	function automatic logic [15:0] hi_mask(input logic [3:0] len);
		if (len <= 8)
			return 16'h0000;
		if (len == 9)
			return 16'h00ff;
		return 16'hffff;
	endfunction

	// ------------------------------------------------------------------------
	// Apply one operation to the shadow table and return its response word
	// ------------------------------------------------------------------------
	function automatic tuat_pkg::result_t apply_table_op(input req_word_t w);
		tuat_pkg::result_t r;
		logic [3:0]        len;
		logic [63:0]       lo;
		logic [15:0]       hi;
		int                slot;
		int                last;
		// Clamp overlong keys, then drop the bytes past the length
		len  = (w.len > tuat_pkg::UidBytes) ? 4'(tuat_pkg::UidBytes) : w.len;
		lo   = w.lo & lo_mask(len);
		hi   = w.hi & hi_mask(len);
		slot = -1;
		// First match wins, scanning from entry 0
		for (int i = 0; i < ent_fill; i++) begin
			if (slot < 0 && ent_len[i] == len && ent_lo[i] == lo && ent_hi[i] == hi)
				slot = i;
		end
		r = '0;
		r.status = tuat_pkg::StOk;
		case (w.op)
			tuat_pkg::OpUpsert: begin
				if (slot < 0) begin
					if (ent_fill >= TableDepth) begin
						r.status = tuat_pkg::StFull;
					end else begin
						slot = ent_fill;
						ent_fill++;
					end
				end
				if (r.status == tuat_pkg::StOk) begin
					ent_lo[slot]  = lo;
					ent_hi[slot]  = hi;
					ent_len[slot] = len;
					ent_act[slot] = w.act;
					ent_par[slot] = w.par;
				end
			end
			tuat_pkg::OpRemove: begin
				if (slot < 0) begin
					r.status = tuat_pkg::StMissing;
				end else begin
					// Fill the hole with the last entry
					last          = ent_fill - 1;
					ent_lo[slot]  = ent_lo[last];
					ent_hi[slot]  = ent_hi[last];
					ent_len[slot] = ent_len[last];
					ent_act[slot] = ent_act[last];
					ent_par[slot] = ent_par[last];
					ent_fill      = last;
				end
			end
			default: begin
				// Lookup, and the spare code acting as one
				if (slot < 0) begin
					r.status = tuat_pkg::StMissing;
				end else begin
					r.found_action = ent_act[slot];
					r.found_param  = ent_par[slot];
				end
			end
		endcase
		r.entry_count = 5'(ent_fill);
		return r;
	endfunction

	function automatic req_word_t word_of(input tuat_pkg::op_code_t op,
			input logic [3:0] len, input logic [63:0] lo, input logic [15:0] hi,
			input logic [7:0] act, input logic [7:0] par);
		req_word_t w;
		w.op  = op;
		w.len = len;
		w.lo  = lo;
		w.hi  = hi;
		w.act = act;
		w.par = par;
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: offer one word, hold it until accepted, log its prediction.
	// Outside steady stretches, drop valid for a random gap between bursts.
	// ------------------------------------------------------------------------
	task automatic send_word(input req_word_t w);
		if (!steady_send && burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		req.valid        <= 1'b1;
		req.op           <= w.op;
		req.key_length   <= w.len;
		req.key_low      <= w.lo;
		req.key_high     <= w.hi;
		req.tag_action   <= w.act;
		req.action_param <= w.par;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		rsp_backlog.push_back(apply_table_op(w));
		if (burst_left > 0)
			burst_left--;
	endtask

	// Drop valid, wait out every pending response, then let the block go quiet
	task automatic settle();
		req.valid <= 1'b0;
		while (rsp_backlog.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Random key handling
	// ------------------------------------------------------------------------
	task automatic make_pool_key(input int k);
		logic [3:0]  len;
		logic [63:0] lo;
		logic [15:0] hi;
		// Mostly real UID sizes: 4, 7 and 10 bytes
		case ($urandom_range(0, 3))
			0: len = 4'd4;
			1: len = 4'd7;
			2: len = 4'd10;
			default: len = 4'($urandom_range(0, tuat_pkg::UidBytes));
		endcase
		lo = {$urandom, $urandom};
		hi = 16'($urandom);
		pool_len[k] = len;
		pool_lo[k]  = lo & lo_mask(len);
		pool_hi[k]  = hi & hi_mask(len);
	endtask

	task automatic refresh_pool(input int count);
		repeat (count)
			make_pool_key($urandom_range(0, PoolSize - 1));
	endtask

	task automatic random_word(input traffic_t phase, output req_word_t w);
		int         roll;
		int         k;
		int         up_lim;
		int         lk_lim;
		int         rm_lim;
		logic [3:0] len;
		case (phase)
			TrGrow: begin
				up_lim = 60; lk_lim = 75; rm_lim = 95;
			end
			TrChurn: begin
				up_lim = 35; lk_lim = 70; rm_lim = 95;
			end
			default: begin
				up_lim = 20; lk_lim = 50; rm_lim = 95;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < up_lim)
			w.op = tuat_pkg::OpUpsert;
		else if (roll < lk_lim)
			w.op = tuat_pkg::OpLookup;
		else if (roll < rm_lim)
			w.op = tuat_pkg::OpRemove;
		else
			w.op = OpSpare;
		w.act = 8'($urandom);
		w.par = 8'($urandom);
		if ($urandom_range(0, 4) != 0) begin
			// Known key with fresh junk in the ignored bytes
			k   = $urandom_range(0, PoolSize - 1);
			len = pool_len[k];
			if (len == tuat_pkg::UidBytes && $urandom_range(0, 2) == 0)
				len = 4'($urandom_range(tuat_pkg::UidBytes, 15));
			w.len = len;
			w.lo  = pool_lo[k] | ({$urandom, $urandom} & ~lo_mask(pool_len[k]));
			w.hi  = pool_hi[k] | (16'($urandom) & ~hi_mask(pool_len[k]));
		end else begin
			// Noise key, almost always a miss
			w.len = 4'($urandom_range(0, 15));
			w.lo  = {$urandom, $urandom};
			w.hi  = 16'($urandom);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Extremes of the fields and each corner of the three operations
	task automatic test_directed_cases();
		steady_send = 1'b0;
		// Empty table: lookup and remove both miss
		send_word(word_of(tuat_pkg::OpLookup, 4'd0, 64'h0, 16'h0, 8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpRemove, 4'd0, 64'h0, 16'h0, 8'h00, 8'h00));
		// Zero-length key: all such keys are the same key
		send_word(word_of(tuat_pkg::OpUpsert, 4'd0, 64'h0, 16'h0, 8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpLookup, 4'd0, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'hff, 8'hff));
		// Full-length key with every bit set and maximum data bytes
		send_word(word_of(tuat_pkg::OpUpsert, 4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'hff, 8'hff));
		// Overlong length clamps to the UID length
		send_word(word_of(tuat_pkg::OpLookup, 4'd15, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'h00, 8'h00));
		// Upsert of an existing key overwrites in place, count unchanged
		send_word(word_of(tuat_pkg::OpUpsert, 4'd12, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'h5a, 8'ha5));
		send_word(word_of(tuat_pkg::OpLookup, 4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'h00, 8'h00));
		// Bytes past the length are ignored on store and on search
		send_word(word_of(tuat_pkg::OpUpsert, 4'd3, 64'hdead_beef_0012_3456, 16'hc3c3,
			8'h11, 8'h22));
		send_word(word_of(tuat_pkg::OpLookup, 4'd3, 64'hffff_ffff_ff12_3456, 16'hffff,
			8'h00, 8'h00));
		// Same bytes with a different length is a different key
		send_word(word_of(tuat_pkg::OpLookup, 4'd4, 64'h0000_0000_0012_3456, 16'h0000,
			8'h00, 8'h00));
		// Spare op code: a lookup that changes nothing, hit and miss
		send_word(word_of(OpSpare, 4'd3, 64'h0000_0000_0012_3456, 16'h0000, 8'h77, 8'h88));
		send_word(word_of(OpSpare, 4'd5, 64'h0000_0001_0203_0405, 16'h0000, 8'h77, 8'h88));
		send_word(word_of(tuat_pkg::OpLookup, 4'd5, 64'h0000_0001_0203_0405, 16'h0000,
			8'h00, 8'h00));
		// Nine-byte key: only the low byte of key_high counts
		send_word(word_of(tuat_pkg::OpUpsert, 4'd9, 64'h0123_4567_89ab_cdef, 16'h55ab,
			8'h33, 8'h44));
		send_word(word_of(tuat_pkg::OpLookup, 4'd9, 64'h0123_4567_89ab_cdef, 16'hc0ab,
			8'h00, 8'h00));
		// Remove entry 0: the last entry moves into its slot
		send_word(word_of(tuat_pkg::OpRemove, 4'd0, 64'h1234, 16'h0, 8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpLookup, 4'd9, 64'h0123_4567_89ab_cdef, 16'h00ab,
			8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpLookup, 4'd0, 64'h0, 16'h0, 8'h00, 8'h00));
		// Remove the last entry, then the rest, then miss on the empty table
		send_word(word_of(tuat_pkg::OpRemove, 4'd3, 64'h0000_0000_0012_3456, 16'h0000,
			8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpRemove, 4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpRemove, 4'd9, 64'h0123_4567_89ab_cdef, 16'h00ab,
			8'h00, 8'h00));
		send_word(word_of(tuat_pkg::OpLookup, 4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff,
			8'h00, 8'h00));
		settle();
	endtask

	// Fill every slot back to back, hit the full case, then drain it again
	task automatic test_fill_to_full();
		logic [63:0] lo[TableDepth];
		logic [3:0]  len[TableDepth];
		steady_send = 1'b1;
		for (int i = 0; i < TableDepth; i++) begin
			len[i] = 4'($urandom_range(4, tuat_pkg::UidBytes));
			lo[i]  = {$urandom, $urandom} & lo_mask(len[i]);
			send_word(word_of(tuat_pkg::OpUpsert, len[i], lo[i], 16'h0,
				8'($urandom), 8'($urandom)));
		end
		// New keys bounce off a full table, an existing one still updates
		send_word(word_of(tuat_pkg::OpUpsert, 4'd10, 64'h0f0f_0f0f_0f0f_0f0f, 16'h0f0f,
			8'h01, 8'h02));
		send_word(word_of(tuat_pkg::OpUpsert, 4'd0, 64'h0, 16'h0, 8'h03, 8'h04));
		send_word(word_of(tuat_pkg::OpUpsert, len[TableDepth - 1], lo[TableDepth - 1],
			16'h0, 8'h9c, 8'hc9));
		for (int i = TableDepth - 1; i >= 0; i--)
			send_word(word_of(tuat_pkg::OpLookup, len[i], lo[i], 16'h0, 8'h00, 8'h00));
		// Remove in a scrambled order so that both middle and last slots go
		for (int i = 0; i < TableDepth; i++) begin
			send_word(word_of(tuat_pkg::OpRemove, len[(i * 5) % TableDepth],
				lo[(i * 5) % TableDepth], 16'h0, 8'h00, 8'h00));
		end
		settle();
	endtask

	// Mostly well-formed traffic on a pool of keys, in grow, churn, shrink phases
	task automatic test_random_traffic();
		req_word_t w;
		traffic_t  phase;
		for (int k = 0; k < PoolSize; k++)
			make_pool_key(k);
		phase = TrGrow;
		for (int n = 0; n < RandomWords; n++) begin
			if (n % PhaseWords == 0) begin
				phase       = traffic_t'($urandom_range(0, 2));
				steady_send = ($urandom_range(0, 3) == 0);
				refresh_pool(3);
			end
			random_word(phase, w);
			send_word(w);
		end
		settle();
	endtask

	// Hold the receiver off for a long stretch while words keep coming
	task automatic test_output_stall();
		req_word_t w;
		steady_send  = 1'b1;
		hold_off_req = HoldOff;
		for (int n = 0; n < 40; n++) begin
			random_word(TrChurn, w);
			send_word(w);
		end
		settle();
	endtask

	// ------------------------------------------------------------------------
	// Receiver and checker: sample handshakes at the edge, then pick the next
	// ready value from the current stall mode or the requested hold-off.
	// ------------------------------------------------------------------------
	initial begin : rsp_side
		int                cyc;
		int                hold_left;
		rx_mode_t          mode;
		tuat_pkg::result_t got;
		tuat_pkg::result_t want;
		cyc       = 0;
		hold_left = 0;
		mode      = RxOpen;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.status       = rsp.status;
				got.found_action = rsp.found_action;
				got.found_param  = rsp.found_param;
				got.entry_count  = rsp.entry_count;
				if (rsp_backlog.size() == 0) begin
					$error("response word with none pending: status %0d count %0d",
						got.status, got.entry_count);
					fail_count++;
				end else begin
					want = rsp_backlog.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.found_action !== want.found_action) begin
						$error("found_action: expected %0h, got %0h",
							want.found_action, got.found_action);
						fail_count++;
					end
					if (got.found_param !== want.found_param) begin
						$error("found_param: expected %0h, got %0h",
							want.found_param, got.found_param);
						fail_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						fail_count++;
					end
				end
			end
			cyc++;
			if (cyc % 300 == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_off_req > 0) begin
				hold_left    = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				case (mode)
					RxOpen:    rsp.ready <= 1'b1;
					RxRandom:  rsp.ready <= ($urandom_range(0, 9) < 6);
					RxPattern: rsp.ready <= ((cyc % 11) < 6);
					default:   rsp.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when neither channel moves a word for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[tag_uid_action_table] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		ent_fill          = 0;
		req.valid        <= 1'b0;
		req.op           <= tuat_pkg::OpLookup;
		req.key_length   <= '0;
		req.key_low      <= '0;
		req.key_high     <= '0;
		req.tag_action   <= '0;
		req.action_param <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_to_full();
		test_random_traffic();
		test_output_stall();
		if (fail_count == 0)
			$display("[tag_uid_action_table] OK");
		else
			$display("[tag_uid_action_table] ERROR");
		$finish;
	end

endmodule

[filelist.f]
design/tuat_pkg.sv
design/tuat_if.sv
design/tuat_ctrl.sv
design/tuat_dp.sv
design/tag_uid_action_table.sv
tb/tb_tag_uid_action_table.sv
